### rtl/tpt_pkg.sv
`default_nettype none

package tpt_pkg;

  // Tempo limits and timer seed.
  localparam int unsigned MIN_BPM    = 32;
  localparam int unsigned MAX_BPM    = 255;
  localparam int unsigned TIMER_SEED = 1773447;

  // Register reset values.
  localparam logic [7:0] BASE_BPM_RESET = 8'd125;
  localparam logic [7:0] FPB_RESET      = 8'd0;

  // Configuration port: two registers at byte addresses 0 and 4.
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_BASE_BPM = 1'b0;
  localparam logic REG_FPB      = 1'b1;

  // Coarse offset limits (10-bit two's complement).
  localparam logic [9:0] COARSE_MAX = 10'h1FF;
  localparam logic [9:0] COARSE_MIN = 10'h200;
  localparam logic [3:0] FINE_MAX   = 4'hF;

  // Divider geometry: radix-4, two quotient bits per cycle.
  localparam int unsigned DIV_NUM_W  = 26;
  localparam int unsigned DIV_DEN_W  = 12;
  localparam logic [3:0] DIV_STEPS_FULL  = 4'd13;
  localparam logic [3:0] DIV_STEPS_SHORT = 4'd9;
  localparam int unsigned DIV_SHORT_SHIFT = 8;

  // Timer numerator is the seed scaled by 16, in the units of the 8.4 tempo.
  localparam logic [DIV_NUM_W-1:0] TIMER_NUM = DIV_NUM_W'(TIMER_SEED * 16);

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_COARSE_UP   = 3'd0,
    OP_COARSE_DOWN = 3'd1,
    OP_FINE_UP     = 3'd2,
    OP_FINE_DOWN   = 3'd3,
    OP_SET_NUDGE   = 3'd4,
    OP_CLEAR       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISP,
    ST_TRACK,
    ST_OUT
  } back_state_e;

  typedef logic [11:0] bpm_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
    logic                 short_mode;
  } div_req_t;

  typedef struct packed {
    logic [11:0] actual_bpm;
    logic [15:0] display_bpm;
    logic [15:0] track_display_bpm;
    logic [15:0] timer_reload;
  } res_t;

  // Saturate a quotient to 16 bits.
  function automatic logic [15:0] sat16(input logic [DIV_NUM_W-1:0] v);
    logic [15:0] r;
    r = (|v[DIV_NUM_W-1:16]) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/tpt_if.sv
`default_nettype none

// Event channel: one word is one pitch-control event.
interface tpt_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic signed [7:0] nudge_value;

  modport source (output valid, output op, output nudge_value, input ready);
  modport sink (input valid, input op, input nudge_value, output ready);
endinterface

// Result channel: one word per event.
interface tpt_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] actual_bpm;
  logic [15:0] display_bpm;
  logic [15:0] track_display_bpm;
  logic [15:0] timer_reload;

  modport source (output valid, output actual_bpm, output display_bpm,
                  output track_display_bpm, output timer_reload, input ready);
  modport sink (input valid, input actual_bpm, input display_bpm,
                input track_display_bpm, input timer_reload, output ready);
endinterface

`default_nettype wire

### rtl/tpt_front.sv
`default_nettype none

module tpt_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  base_bpm_i,
  tpt_in_if.sink           in_i,
  input  wire logic        q_full_i,
  output tpt_pkg::bpm_t    push_data_o,
  output logic             push_o
);
  import tpt_pkg::*;

  logic [9:0] coarse_q, coarse_d;
  logic [3:0] fine_q, fine_d;
  logic [7:0] nudge_q, nudge_d;

  logic signed [10:0] sum_cur, sum_new;
  logic signed [11:0] adj, adj_c;
  logic               can_up, can_down, accept;
  op_e                op;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign op         = op_e'(in_i.op);

  // Coarse limits are checked on the sum before the event.
  assign sum_cur  = $signed({3'b000, base_bpm_i}) + $signed({coarse_q[9], coarse_q});
  assign can_up   = (sum_cur < $signed(11'(MAX_BPM))) && (coarse_q != COARSE_MAX);
  assign can_down = (sum_cur > $signed(11'(MIN_BPM))) && (coarse_q != COARSE_MIN);

  // Apply the event to the adjustment state.
  always_comb begin
    coarse_d = coarse_q;
    fine_d   = fine_q;
    nudge_d  = nudge_q;
    unique case (op)
      OP_COARSE_UP: begin
        if (can_up) coarse_d = coarse_q + 10'd1;
      end
      OP_COARSE_DOWN: begin
        if (can_down) coarse_d = coarse_q - 10'd1;
      end
      OP_FINE_UP: begin
        if (fine_q != FINE_MAX) begin
          fine_d = fine_q + 4'd1;
        end else if (can_up) begin
          coarse_d = coarse_q + 10'd1;
          fine_d   = 4'd0;
        end
      end
      OP_FINE_DOWN: begin
        if (fine_q != 4'd0) begin
          fine_d = fine_q - 4'd1;
        end else if (can_down) begin
          coarse_d = coarse_q - 10'd1;
          fine_d   = FINE_MAX;
        end
      end
      OP_SET_NUDGE: begin
        nudge_d = in_i.nudge_value;
      end
      OP_CLEAR: begin
        coarse_d = '0;
        fine_d   = '0;
        nudge_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Clamp the adjusted tempo and form it in 8.4 fixed point.
  assign sum_new = $signed({3'b000, base_bpm_i}) + $signed({coarse_d[9], coarse_d});
  assign adj     = $signed({sum_new[10], sum_new}) + $signed({{4{nudge_d[7]}}, nudge_d});

  always_comb begin
    adj_c = adj;
    if (adj < $signed(12'(MIN_BPM))) adj_c = $signed(12'(MIN_BPM));
    if (adj_c > $signed(12'(MAX_BPM))) adj_c = $signed(12'(MAX_BPM));
  end

  assign push_data_o = {adj_c[7:0], fine_d};
  assign push_o      = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_q <= '0;
      fine_q   <= '0;
      nudge_q  <= '0;
    end else if (accept) begin
      coarse_q <= coarse_d;
      fine_q   <= fine_d;
      nudge_q  <= nudge_d;
    end
  end

endmodule

`default_nettype wire

### rtl/tpt_queue.sv
`default_nettype none

module tpt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tpt_pkg::bpm_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output tpt_pkg::bpm_t      pop_data_o
);
  import tpt_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  bpm_t                mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Storage for queued tempos.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) count_q <= count_q + (PtrW+1)'(1);
      else if (do_pop && !do_push) count_q <= count_q - (PtrW+1)'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/tpt_div.sv
`default_nettype none

module tpt_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire tpt_pkg::div_req_t            req_i,
  output logic                              done_o,
  output logic [tpt_pkg::DIV_NUM_W-1:0]     quot_o
);
  import tpt_pkg::*;

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_NUM_W-1:0] quot_q, quot_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q, rem_d, rem1;
  logic [DIV_DEN_W:0]   t1, t2;
  logic [3:0]           cnt_q;
  logic                 busy_q, done_q, ge1, ge2;

  // Two restoring steps per cycle.
  always_comb begin
    t1     = {rem_q, num_q[DIV_NUM_W-1]};
    ge1    = (t1 >= {1'b0, den_q});
    rem1   = ge1 ? DIV_DEN_W'(t1 - {1'b0, den_q}) : t1[DIV_DEN_W-1:0];
    t2     = {rem1, num_q[DIV_NUM_W-2]};
    ge2    = (t2 >= {1'b0, den_q});
    rem_d  = ge2 ? DIV_DEN_W'(t2 - {1'b0, den_q}) : t2[DIV_DEN_W-1:0];
    num_d  = {num_q[DIV_NUM_W-3:0], 2'b00};
    quot_d = {quot_q[DIV_NUM_W-3:0], ge1, ge2};
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= req_i.short_mode ? (req_i.dividend << DIV_SHORT_SHIFT) : req_i.dividend;
      den_q  <= req_i.divisor;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_mode ? DIV_STEPS_SHORT : DIV_STEPS_FULL;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### rtl/tpt_back.sv
`default_nettype none

module tpt_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    base_bpm_i,
  input  wire logic [7:0]    fpb_i,
  input  wire logic          q_valid_i,
  input  wire tpt_pkg::bpm_t q_data_i,
  output logic               pop_o,
  tpt_out_if.source          out_o
);
  import tpt_pkg::*;

  back_state_e state_q, state_d;

  bpm_t                 act_q;
  logic [15:0]          timer_q, disp_q;
  res_t                 res_q;
  logic                 out_valid_q;

  div_req_t             tmr_req, dsp_req;
  logic                 tmr_start, dsp_start, tmr_done, dsp_done;
  logic [DIV_NUM_W-1:0] tmr_quot, dsp_quot;
  logic                 start_item, start_track, load_out, out_free, fpb_zero;
  logic [16:0]          disp_num, track_num;
  bpm_t                 act_src;

  assign out_free = !out_valid_q || out_o.ready;
  assign fpb_zero = (fpb_i == 8'd0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = ST_DISP;
      ST_DISP:  if (dsp_done) state_d = ST_TRACK;
      ST_TRACK: if (dsp_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    start_item  = 1'b0;
    start_track = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE:  start_item  = q_valid_i;
      ST_DISP:  start_track = dsp_done;
      ST_TRACK: ;
      ST_OUT:   load_out    = out_free;
      default:  ;
    endcase
  end

  assign pop_o = start_item;

  // Display numerators: tempo times 24.
  assign act_src   = start_item ? q_data_i : act_q;
  assign disp_num  = {1'b0, act_src, 4'b0000} + {2'b00, act_src, 3'b000};
  assign track_num = {1'b0, base_bpm_i, 8'h00} + {2'b00, base_bpm_i, 7'h00};

  assign tmr_start = start_item;
  assign dsp_start = start_item || start_track;

  always_comb begin
    tmr_req.dividend   = TIMER_NUM;
    tmr_req.divisor    = q_data_i;
    tmr_req.short_mode = 1'b0;
    dsp_req.dividend   = start_track ? DIV_NUM_W'(track_num) : DIV_NUM_W'(disp_num);
    dsp_req.divisor    = DIV_DEN_W'(fpb_i);
    dsp_req.short_mode = 1'b1;
  end

  tpt_div u_tmr_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tmr_start),
    .req_i   (tmr_req),
    .done_o  (tmr_done),
    .quot_o  (tmr_quot)
  );

  tpt_div u_dsp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dsp_start),
    .req_i   (dsp_req),
    .done_o  (dsp_done),
    .quot_o  (dsp_quot)
  );

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (start_item) act_q <= q_data_i;
    if (tmr_done) timer_q <= (act_q == '0) ? 16'hFFFF : sat16(tmr_quot);
    if (start_track) disp_q <= fpb_zero ? {4'h0, act_q} : sat16(dsp_quot);
    if (load_out) begin
      res_q.actual_bpm        <= act_q;
      res_q.display_bpm       <= disp_q;
      res_q.track_display_bpm <= fpb_zero ? {4'h0, base_bpm_i, 4'h0} : sat16(dsp_quot);
      res_q.timer_reload      <= timer_q;
    end
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.actual_bpm        = res_q.actual_bpm;
  assign out_o.display_bpm       = res_q.display_bpm;
  assign out_o.track_display_bpm = res_q.track_display_bpm;
  assign out_o.timer_reload      = res_q.timer_reload;

endmodule

`default_nettype wire

### rtl/tempo_pitch_timer_calc_core.sv
// The back end takes one event at a time and starts the next only once the result
// word of the last is loaded: two 9-step display divisions in turn in the shared
// radix-4 divider, the result load, which waits while the output is stalled, and
// the return to idle; the timer division (13 steps) runs beside them. A two-word queue
// takes events meanwhile. Reset (rst_ni low, asynchronous): base tempo 125, display
// scaling off, all pitch adjustments zero, queue and output empty.
`default_nettype none

module tempo_pitch_timer_calc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tpt_in_if.sink                             in_i,
  tpt_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tpt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tpt_pkg::*;

  logic [7:0] base_bpm_q, fpb_q;
  logic       cfg_wr, q_full, q_valid, push, pop;
  bpm_t       push_data, pop_data;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_bpm_q <= BASE_BPM_RESET;
      fpb_q      <= FPB_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE_BPM) base_bpm_q <= pwdata[7:0];
      else fpb_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_FPB) ? {24'h0, fpb_q} : {24'h0, base_bpm_q};

  tpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_bpm_i  (base_bpm_q),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_data_o (push_data),
    .push_o      (push)
  );

  tpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  tpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .base_bpm_i (base_bpm_q),
    .fpb_i      (fpb_q),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

### dv/tpt_tempo_checker.sv
// Watches the event and result channels and the configuration port of the
// tempo calculator. Keeps its own copy of the pitch state and the registers,
// predicts one result word per accepted event word and compares every
// accepted result word with the oldest prediction.
module tpt_tempo_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tpt_in_if                                   evt_mon,
  tpt_out_if                                  res_mon,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tpt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  input  wire logic                           pready,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o
);
  import tpt_pkg::*;

  // Shadow registers and pitch state.
  logic [7:0]        base_bpm_q;
  logic [7:0]        fpb_q;
  logic signed [9:0] coarse_q;
  logic [3:0]        fine_q;
  logic signed [7:0] nudge_q;

  // Result words predicted but not yet seen, oldest first.
  res_t        tempo_due[$];
  int unsigned mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic logic [15:0] clip16(input longint v);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // Applies one event to the pitch state and forms the result word.
  function automatic res_t next_tempo(input logic [2:0] op, input logic signed [7:0] nudge_in);
    int         sum;
    int         adj;
    bit         up_ok;
    bit         down_ok;
    logic [11:0] act;
    res_t       r;
    sum     = int'(base_bpm_q) + int'(coarse_q);
    up_ok   = (sum < int'(MAX_BPM)) && (coarse_q < $signed(COARSE_MAX));
    down_ok = (sum > int'(MIN_BPM)) && (coarse_q > $signed(COARSE_MIN));
    case (op)
      OP_COARSE_UP: begin
        if (up_ok) coarse_q++;
      end
      OP_COARSE_DOWN: begin
        if (down_ok) coarse_q--;
      end
      OP_FINE_UP: begin
        // At the top of the fraction a step carries into the coarse offset, if the coarse limits allow.
        if (fine_q != FINE_MAX) begin
          fine_q++;
        end else if (up_ok) begin
          coarse_q++;
          fine_q = '0;
        end
      end
      OP_FINE_DOWN: begin
        // At zero a step borrows from the coarse offset, if the coarse limits allow.
        if (fine_q != '0) begin
          fine_q--;
        end else if (down_ok) begin
          coarse_q--;
          fine_q = FINE_MAX;
        end
      end
      OP_SET_NUDGE: begin
        nudge_q = nudge_in;
      end
      OP_CLEAR: begin
        coarse_q = '0;
        fine_q   = '0;
        nudge_q  = '0;
      end
      default: begin
      end
    endcase

    // Clamp the lower bound first, then the upper one.
    adj = int'(base_bpm_q) + int'(coarse_q) + int'(nudge_q);
    if (adj < int'(MIN_BPM)) adj = int'(MIN_BPM);
    if (adj > int'(MAX_BPM)) adj = int'(MAX_BPM);
    if (adj < 0) adj = 0;
    act = 12'((adj * 16) | int'(fine_q));

    r.actual_bpm = act;
    if (fpb_q != '0) begin
      r.display_bpm       = clip16(longint'(act) * 24 / longint'(fpb_q));
      r.track_display_bpm = clip16(longint'(base_bpm_q) * 16 * 24 / longint'(fpb_q));
    end else begin
      r.display_bpm       = 16'(act);
      r.track_display_bpm = 16'(longint'(base_bpm_q) * 16);
    end
    r.timer_reload = (act == '0) ? 16'hFFFF :
                     clip16(longint'(TIMER_SEED) * 16 / longint'(act));
    return r;
  endfunction

  // Compare outgoing words first, then track register writes, then predict
  // for the incoming word of this edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      base_bpm_q = BASE_BPM_RESET;
      fpb_q      = FPB_RESET;
      coarse_q   = '0;
      fine_q     = '0;
      nudge_q    = '0;
      tempo_due.delete();
      pending_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (tempo_due.size() == 0) begin
          report_mismatch("result word with no event word waiting");
        end else begin
          want = tempo_due.pop_front();
          if (res_mon.actual_bpm != want.actual_bpm)
            report_mismatch($sformatf("actual_bpm got %0d, expected %0d",
                                      res_mon.actual_bpm, want.actual_bpm));
          if (res_mon.display_bpm != want.display_bpm)
            report_mismatch($sformatf("display_bpm got %0d, expected %0d",
                                      res_mon.display_bpm, want.display_bpm));
          if (res_mon.track_display_bpm != want.track_display_bpm)
            report_mismatch($sformatf("track_display_bpm got %0d, expected %0d",
                                      res_mon.track_display_bpm, want.track_display_bpm));
          if (res_mon.timer_reload != want.timer_reload)
            report_mismatch($sformatf("timer_reload got %0d, expected %0d",
                                      res_mon.timer_reload, want.timer_reload));
        end
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_BASE_BPM) begin
          base_bpm_q = pwdata[7:0];
        end else begin
          fpb_q = pwdata[7:0];
        end
      end

      if (evt_mon.valid && evt_mon.ready) begin
        tempo_due.push_back(next_tempo(evt_mon.op, evt_mon.nudge_value));
      end
      pending_o <= tempo_due.size();
    end
  end

endmodule

### dv/tb_tempo_pitch_timer_calc_core.sv
// Drives pitch-control event words and register writes into the tempo
// calculator, with random idling on both channels; the checker beside the
// block predicts and compares every result word.
module tb_tempo_pitch_timer_calc_core;
  import tpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PHASE_ITEMS   = 230;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned MAX_GAP       = 60;

  // Op codes the block treats as no change.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           cycles = 0;
  idle_mode_e            idle_mode = IDLE_NONE;

  logic [2:0] step_ops [4] = '{OP_COARSE_UP, OP_COARSE_DOWN, OP_FINE_UP, OP_FINE_DOWN};

  tpt_in_if  evt_if();
  tpt_out_if res_if();

  tempo_pitch_timer_calc_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (evt_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tpt_tempo_checker tempo_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_mon      (evt_if),
    .res_mon      (res_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result receiver: stalls at random in the receiver idling modes.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      case (idle_mode)
        IDLE_RECEIVER: res_if.ready <= ($urandom_range(99) >= 78);
        IDLE_BOTH:     res_if.ready <= ($urandom_range(99) >= 29);
        default:       res_if.ready <= 1'b1;
      endcase
    end
  end

  // Offers one event word after a random gap and waits until it is taken.
  // Valid stays high into the next word when there is no gap.
  task automatic send_event(input logic [2:0] op, input logic [7:0] nv);
    int unsigned gap;
    int unsigned pct;
    gap = 0;
    pct = (idle_mode == IDLE_SENDER) ? 78 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_if.valid       <= 1'b1;
    evt_if.op          <= op;
    evt_if.nudge_value <= nv;
    do @(posedge clk_i); while (!evt_if.ready);
  endtask

  // Stops offering words and waits until every result word has been taken.
  task automatic wait_drained();
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Setup and access cycles, then the bus returns to idle.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Favors the edge values of a register but also draws any byte.
  function automatic logic [7:0] pick_reg_value(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
    case ($urandom_range(4))
      0:       return a;
      1:       return b;
      2:       return c;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    logic [2:0]  op;

    evt_if.valid       <= 1'b0;
    evt_if.op          <= OP_COARSE_UP;
    evt_if.nudge_value <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: single steps, borrow and carry, nudge extremes, spare ops.
    send_event(OP_COARSE_UP, 8'h00);
    send_event(OP_COARSE_DOWN, 8'hFF);
    send_event(OP_FINE_DOWN, 8'h00);
    send_event(OP_FINE_UP, 8'hFF);
    send_event(OP_FINE_UP, 8'h55);
    send_event(OP_SET_NUDGE, 8'h7F);
    send_event(OP_SET_NUDGE, 8'h80);
    send_event(OP_SPARE_6, 8'hAA);
    send_event(OP_SPARE_7, 8'h01);
    send_event(OP_CLEAR, 8'hFF);

    // Top tempo: coarse up blocked, clamp from above, carry blocked.
    wait_drained();
    write_reg(REG_BASE_BPM, 8'd255);
    write_reg(REG_FPB, 8'd1);
    send_event(OP_COARSE_UP, 8'h00);
    send_event(OP_SET_NUDGE, 8'h7F);
    send_event(OP_FINE_DOWN, 8'h00);
    send_event(OP_COARSE_UP, 8'h00);
    send_event(OP_FINE_UP, 8'h00);

    // Zero base: coarse down and borrow blocked, clamp from below.
    wait_drained();
    write_reg(REG_BASE_BPM, 8'd0);
    write_reg(REG_FPB, 8'd255);
    send_event(OP_CLEAR, 8'h00);
    send_event(OP_COARSE_DOWN, 8'h00);
    send_event(OP_FINE_DOWN, 8'h00);
    send_event(OP_SET_NUDGE, 8'h80);
    send_event(OP_COARSE_UP, 8'h00);

    // Base at the minimum tempo.
    wait_drained();
    write_reg(REG_BASE_BPM, 8'(MIN_BPM));
    write_reg(REG_FPB, 8'd24);
    send_event(OP_CLEAR, 8'h00);
    send_event(OP_COARSE_DOWN, 8'h00);
    send_event(OP_FINE_UP, 8'h00);

    // Random phases: bursts of one step op drive the offsets into the limits.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      write_reg(REG_BASE_BPM, pick_reg_value(8'd0, 8'(MIN_BPM), 8'd255));
      write_reg(REG_FPB, pick_reg_value(8'd0, 8'd1, 8'd255));
      idle_mode = idle_mode_e'(p % 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick  = $urandom_range(99);
        burst = 1;
        if (pick < 60) begin
          op    = step_ops[$urandom_range(3)];
          burst = $urandom_range(1, 24);
        end else if (pick < 80) begin
          op = step_ops[$urandom_range(3)];
        end else if (pick < 90) begin
          op = OP_SET_NUDGE;
        end else if (pick < 95) begin
          op = OP_CLEAR;
        end else begin
          op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
        end
        repeat (burst) begin
          send_event(op, 8'($urandom_range(255)));
          sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
